@@ hw/rtl/gasd_pkg.sv @@
`timescale 1ns / 1ps

package gasd_pkg;

    // widths of the data path
    localparam int RAW_W   = 32;
    localparam int NORM_W  = 10;
    localparam int NUM_W   = RAW_W + NORM_W + 1;

    // scaled range and centre
    localparam logic [NORM_W-1:0] NORM_MAX     = 10'd1023;
    localparam logic [NORM_W-1:0] STICK_OFFSET = 10'd512;

    // register stages inside one lane: prepare, numerator, one per quotient bit
    localparam int LANE_DEPTH = NORM_W + 2;

    // register indexes
    typedef enum logic [2:0] {
        REG_X_MIN       = 3'd0,
        REG_X_MAX       = 3'd1,
        REG_Y_MIN       = 3'd2,
        REG_Y_MAX       = 3'd3,
        REG_TRIGGER_MIN = 3'd4,
        REG_TRIGGER_MAX = 3'd5,
        REG_DEADZONE    = 3'd6
    } reg_index_t;

    // one lane result
    typedef struct packed {
        logic              empty;
        logic [NORM_W-1:0] norm;
    } lane_result_t;

endpackage

@@ hw/rtl/gasd_lane.sv @@
`timescale 1ns / 1ps

module gasd_lane
(
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [gasd_pkg::RAW_W-1:0] value,
    input  logic signed [gasd_pkg::RAW_W-1:0] lo,
    input  logic signed [gasd_pkg::RAW_W-1:0] hi,
    output gasd_pkg::lane_result_t         result
);

    localparam int RW = gasd_pkg::RAW_W;
    localparam int QW = gasd_pkg::NORM_W;
    localparam int NW = gasd_pkg::NUM_W;

    // prepare stage: clamp, offset and span
    logic [RW-1:0]       d_reg;
    logic [RW-1:0]       span_p_reg;
    logic                empty_p_reg;
    logic signed [RW-1:0] clamped;
    logic signed [RW:0]  d_wide;
    logic signed [RW:0]  span_wide;

    always_comb
    begin
        if (value < lo)
            clamped = lo;
        else if (value > hi)
            clamped = hi;
        else
            clamped = value;
        d_wide    = {clamped[RW-1], clamped} - {lo[RW-1], lo};
        span_wide = {hi[RW-1], hi} - {lo[RW-1], lo};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg       <= d_wide[RW-1:0];
            span_p_reg  <= span_wide[RW-1:0];
            empty_p_reg <= (hi <= lo);
        end
    end

    // numerator stage: d*1023 + span/2, split into remainder head and low bits
    logic [NW-1:0] num;
    logic [RW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic [RW-1:0] span_reg [QW+1];
    logic          empty_reg [QW+1];

    always_comb
    begin
        num = {1'b0, d_reg, {QW{1'b0}}} - {{(QW+1){1'b0}}, d_reg}
            + {{(QW+2){1'b0}}, span_p_reg[RW-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= num[NW-2:QW];
            low_reg[0]   <= num[QW-1:0];
            quo_reg[0]   <= '0;
            span_reg[0]  <= span_p_reg;
            empty_reg[0] <= empty_p_reg;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [RW:0] trial;
        logic        fits;

        always_comb
        begin
            trial = {rem_reg[k], low_reg[k][QW-1-k]};
            fits  = (trial >= {1'b0, span_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]   <= fits ? RW'(trial - {1'b0, span_reg[k]}) : RW'(trial);
                low_reg[k+1]   <= low_reg[k];
                quo_reg[k+1]   <= quo_reg[k] | (QW'(fits) << (QW-1-k));
                span_reg[k+1]  <= span_reg[k];
                empty_reg[k+1] <= empty_reg[k];
            end
        end
    end

    assign result.empty = empty_reg[QW];
    assign result.norm  = quo_reg[QW];

endmodule

@@ hw/rtl/gamepad_axis_scale_deadzone_unit.sv @@
`timescale 1ns / 1ps
// path: a request runs through the lane registers, square stage and output register
// throughput: one per cycle unless stalled; 10-stage pipelined restoring dividers
// stalls: the whole pipeline holds while a result waits on the output
// reset: rst_n clears all valid bits and loads the register defaults
// (ranges 0..255, deadzone off)
module gamepad_axis_scale_deadzone_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] raw_x,
    input  logic signed [31:0] raw_y,
    input  logic signed [31:0] raw_trigger,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [9:0]  axis_x,
    output logic signed [9:0]  axis_y,
    output logic [9:0]         trigger_level
);

    localparam int DEPTH = gasd_pkg::LANE_DEPTH;

    // configuration registers
    logic signed [31:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic signed [31:0] trigger_min_reg, trigger_max_reg;
    logic [9:0]         deadzone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg       <= 32'sd0;
            x_max_reg       <= 32'sd255;
            y_min_reg       <= 32'sd0;
            y_max_reg       <= 32'sd255;
            trigger_min_reg <= 32'sd0;
            trigger_max_reg <= 32'sd255;
            deadzone_reg    <= 10'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gasd_pkg::REG_X_MIN:       x_min_reg       <= cfg_data;
                gasd_pkg::REG_X_MAX:       x_max_reg       <= cfg_data;
                gasd_pkg::REG_Y_MIN:       y_min_reg       <= cfg_data;
                gasd_pkg::REG_Y_MAX:       y_max_reg       <= cfg_data;
                gasd_pkg::REG_TRIGGER_MIN: trigger_min_reg <= cfg_data;
                gasd_pkg::REG_TRIGGER_MAX: trigger_max_reg <= cfg_data;
                gasd_pkg::REG_DEADZONE:    deadzone_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // global advance: pipeline moves unless the output holds a result
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // valid bits alongside the lanes
    logic [DEPTH-1:0] vld_reg;
    logic             sq_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            sq_vld_reg <= 1'b0;
            out_valid  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg    <= {vld_reg[DEPTH-2:0], in_valid};
            sq_vld_reg <= vld_reg[DEPTH-1];
            out_valid  <= sq_vld_reg;
        end
    end

    // three scaling lanes
    gasd_pkg::lane_result_t res_x, res_y, res_t;

    gasd_lane u_lane_x (.clk(clk), .en(en), .value(raw_x), .lo(x_min_reg),
                        .hi(x_max_reg), .result(res_x));
    gasd_lane u_lane_y (.clk(clk), .en(en), .value(raw_y), .lo(y_min_reg),
                        .hi(y_max_reg), .result(res_y));
    gasd_lane u_lane_t (.clk(clk), .en(en), .value(raw_trigger), .lo(trigger_min_reg),
                        .hi(trigger_max_reg), .result(res_t));

    // centre the sticks and square for the deadzone test
    logic signed [9:0] sx, sy;
    logic [9:0]        st;
    logic signed [9:0] sx_reg, sy_reg;
    logic [9:0]        st_reg;
    logic [18:0]       x2_reg, y2_reg;
    logic [19:0]       dz2_reg;
    logic              dz_on_reg;
    logic signed [19:0] x2_full, y2_full;

    always_comb
    begin
        sx = res_x.empty ? 10'sd0 : $signed(res_x.norm - gasd_pkg::STICK_OFFSET);
        sy = res_y.empty ? 10'sd0 : $signed(res_y.norm - gasd_pkg::STICK_OFFSET);
        st = res_t.empty ? 10'd0 : res_t.norm;
        x2_full = sx * sx;
        y2_full = sy * sy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg    <= sx;
            sy_reg    <= sy;
            st_reg    <= st;
            x2_reg    <= x2_full[18:0];
            y2_reg    <= y2_full[18:0];
            dz2_reg   <= deadzone_reg * deadzone_reg;
            dz_on_reg <= (deadzone_reg != 10'd0);
        end
    end

    // deadzone compare into the output register
    logic [19:0] mag2;
    logic        inside_dz;

    always_comb
    begin
        mag2      = {1'b0, x2_reg} + {1'b0, y2_reg};
        inside_dz = dz_on_reg && (mag2 <= dz2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            axis_x        <= inside_dz ? 10'sd0 : sx_reg;
            axis_y        <= inside_dz ? 10'sd0 : sy_reg;
            trigger_level <= st_reg;
        end
    end

`ifndef SYNTHESIS
    // a finished item in the square stage is never dropped during a stall
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && sq_vld_reg) |=> sq_vld_reg)
        else $error("square stage lost an item while stalled");

    // centred zero sticks give zero axes
    a_zero_stick: assert property (@(posedge clk) disable iff (!rst_n)
        (en && sq_vld_reg && sx_reg == 10'sd0 && sy_reg == 10'sd0)
        |=> (axis_x == 10'sd0 && axis_y == 10'sd0))
        else $error("zero stick did not give zero axes");

    // deadzone squares never exceed 1023 squared (1046529)
    a_dz_range: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg |-> (dz2_reg <= 20'd1046529))
        else $error("deadzone square out of range");
`endif

endmodule
